@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers, expect clk and rst_n in scope
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge out of reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression is never true out of reset
`define ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ rtl/ipt_pkg.sv @@
// ----------------------------------------------------------------------------
// ipt_pkg
// shared types and constants of the interlaced push transition
// ----------------------------------------------------------------------------
package ipt_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int PROG_W    = 13;
    localparam int COL_W     = 12;
    localparam int ROW_W     = 12;
    localparam int TICK_W    = 32;
    localparam int PROD_W    = PROG_W + TICK_W;
    localparam int QUOT_W    = PROG_W;
    localparam int CNT_W     = $clog2(QUOT_W);
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 32;

    localparam logic [TICK_W-1:0] DURATION_RST = TICK_W'(1000);
    localparam logic [PROG_W-1:0] WIDTH_RST    = PROG_W'(640);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DURATION    = 1'b0,
        REG_IMAGE_WIDTH = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        REQ_FRAME_TICK  = 1'b0,
        REQ_PIXEL_QUERY = 1'b1
    } req_kind_t;

    // result payload
    typedef struct packed {
        logic              use_second;
        logic [COL_W-1:0]  source_column;
        logic [PROG_W-1:0] progress;
        logic              finished;
    } map_res_t;

    // divider launch and operands
    typedef struct packed {
        logic              start;
        logic [PROG_W-1:0] width;
        logic [TICK_W-1:0] elapsed;
        logic [TICK_W-1:0] duration;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ rtl/ipt_stream_if.sv @@
// ----------------------------------------------------------------------------
// ipt_req_if / ipt_rsp_if
// valid/ready channels for request items and result items
// ----------------------------------------------------------------------------
interface ipt_req_if;
    import ipt_pkg::*;

    logic              valid;
    logic              ready;
    logic              req_type;
    logic [TICK_W-1:0] tick;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  column;

    modport source (output valid, req_type, tick, row, column, input ready);
    modport sink   (input valid, req_type, tick, row, column, output ready);
endinterface

interface ipt_rsp_if;
    import ipt_pkg::*;

    logic              valid;
    logic              ready;
    logic              use_second;
    logic [COL_W-1:0]  source_column;
    logic [PROG_W-1:0] progress;
    logic              finished;

    modport source (output valid, use_second, source_column, progress, finished,
                    input ready);
    modport sink   (input valid, use_second, source_column, progress, finished,
                    output ready);
endinterface

@@ rtl/interlaced_push_transition.sv @@
// ----------------------------------------------------------------------------
// interlaced_push_transition
// push transition mapper: even lines slide in from the left, odd from the right
// ----------------------------------------------------------------------------
// A pixel query is answered in the cycle after its transfer, and a new query
// is taken every cycle while the result side keeps up; the answer sits in an
// output register, and while a result waits there the request side is held
// off until it leaves. A frame tick first forms the elapsed time, then
// compares it with the duration and, while the transition is still running,
// loads width times elapsed time into the divider, runs 13 restoring divide
// steps and registers the result; once elapsed time reaches the duration the
// compare registers the result directly, without a divide. No request is
// taken while a tick is in flight. The divider's single 33-bit subtractor
// sets the tick latency. Elapsed time is tick minus the first tick seen after
// reset, modulo 2^32; progress is width*elapsed/duration, saturated at the
// width. Registers (duration at index 0, image width at index 1) are to be
// written through cfg_we/cfg_index/cfg_data only while no item is in flight;
// the block does not enforce this. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module interlaced_push_transition
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ipt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ipt_pkg::CFG_DAT_W-1:0] cfg_data,
    ipt_req_if.sink                       req_ch,
    ipt_rsp_if.source                     rsp_ch
);
    import ipt_pkg::*;

    `include "assert_macros.svh"

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CMP  = 3'b010,
        ST_DIV  = 3'b100
    } state_t;

    state_t            state_reg;
    state_t            state_next;

    // configuration registers
    logic [TICK_W-1:0] duration_reg;
    logic [PROG_W-1:0] width_reg;

    // transition state
    logic              first_reg;
    logic              first_next;
    logic [TICK_W-1:0] start_reg;
    logic [TICK_W-1:0] start_next;
    logic [PROG_W-1:0] slide_reg;
    logic [PROG_W-1:0] slide_next;
    logic [TICK_W-1:0] elapsed_reg;
    logic [TICK_W-1:0] elapsed_next;

    // output register
    logic              out_valid_reg;
    logic              out_valid_next;
    map_res_t          out_reg;
    map_res_t          out_next;

    logic [PROG_W-1:0] eff_w;
    logic              req_xfer;
    logic              rsp_xfer;
    logic              out_free;
    logic              elapsed_done;
    logic [PROG_W-1:0] map_slide;
    logic [PROG_W-1:0] tick_slide;
    map_res_t          map_res;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    // width saturates at the largest supported image
    assign eff_w = (width_reg > PROG_W'(MAX_WIDTH)) ? PROG_W'(MAX_WIDTH) : width_reg;

    assign out_free     = !out_valid_reg || rsp_ch.ready;
    assign req_ch.ready = (state_reg == ST_IDLE) && out_free;
    assign req_xfer     = req_ch.valid && req_ch.ready;
    assign rsp_xfer     = out_valid_reg && rsp_ch.ready;

    assign elapsed_done = (elapsed_reg >= duration_reg);

    // slide amount a tick ends with, saturated or from the divider
    assign tick_slide = elapsed_done ? eff_w : div_rsp.quotient;

    // map uses the stored slide for queries and the fresh one for ticks
    assign map_slide = (state_reg == ST_IDLE) ? slide_reg : tick_slide;

    ipt_map u_map
    (
        .odd_row   (req_ch.row[0]),
        .column    (req_ch.column),
        .eff_width (eff_w),
        .slide     (map_slide),
        .res       (map_res)
    );

    // launch the divide only when the transition is still running
    assign div_req.start    = (state_reg == ST_CMP) && !elapsed_done;
    assign div_req.width    = eff_w;
    assign div_req.elapsed  = elapsed_reg;
    assign div_req.duration = duration_reg;

    ipt_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        first_next     = first_reg;
        start_next     = start_reg;
        slide_next     = slide_reg;
        elapsed_next   = elapsed_reg;
        out_valid_next = out_valid_reg && !rsp_xfer;
        out_next       = out_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_xfer)
                begin
                    if (req_ch.req_type == REQ_PIXEL_QUERY)
                    begin
                        out_next       = map_res;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        // first tick sets the time origin
                        if (first_reg)
                        begin
                            first_next   = 1'b0;
                            start_next   = req_ch.tick;
                            elapsed_next = '0;
                        end
                        else
                        begin
                            elapsed_next = req_ch.tick - start_reg;
                        end
                        state_next = ST_CMP;
                    end
                end
            end
            ST_CMP:
            begin
                if (elapsed_done)
                begin
                    slide_next               = tick_slide;
                    out_next                 = map_res;
                    out_next.use_second      = 1'b0;
                    out_next.source_column   = '0;
                    out_valid_next           = 1'b1;
                    state_next               = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    slide_next               = tick_slide;
                    out_next                 = map_res;
                    out_next.use_second      = 1'b0;
                    out_next.source_column   = '0;
                    out_valid_next           = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            duration_reg  <= DURATION_RST;
            width_reg     <= WIDTH_RST;
            first_reg     <= 1'b1;
            start_reg     <= '0;
            slide_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            start_reg     <= start_next;
            slide_reg     <= slide_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DURATION:    duration_reg <= cfg_data[TICK_W-1:0];
                    REG_IMAGE_WIDTH: width_reg    <= cfg_data[PROG_W-1:0];
                    default:         ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        elapsed_reg <= elapsed_next;
        out_reg     <= out_next;
    end

    assign rsp_ch.valid         = out_valid_reg;
    assign rsp_ch.use_second    = out_reg.use_second;
    assign rsp_ch.source_column = out_reg.source_column;
    assign rsp_ch.progress      = out_reg.progress;
    assign rsp_ch.finished      = out_reg.finished;

    // slide amount never passes the largest image width
    `ASSERT_CLK(a_slide_bounded, slide_reg <= PROG_W'(MAX_WIDTH), "slide amount above max width")

    // the divider only reports while the sequencer waits for it
    `ASSERT_CLK(a_div_done_in_div, div_rsp.done |-> (state_reg == ST_DIV), "divide done outside wait")

    // a running transition always ends below the full width
    `ASSERT_CLK(a_quot_below_width, div_rsp.done |-> ((div_rsp.quotient < eff_w) || (eff_w == '0)), "quotient reached width")

    // a tick result lands only when the output register is empty
    `ASSERT_NEVER(a_no_overwrite, (state_reg != ST_IDLE) && (state_next == ST_IDLE) && out_valid_reg && !rsp_ch.ready, "result overwritten")

endmodule

@@ rtl/ipt_div.sv @@
// ----------------------------------------------------------------------------
// ipt_div
// width * elapsed / duration, one multiply then one quotient bit per cycle
// ----------------------------------------------------------------------------
module ipt_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  ipt_pkg::div_req_t req,
    output ipt_pkg::div_rsp_t rsp
);
    import ipt_pkg::*;

    logic [TICK_W-1:0] rem_reg;
    logic [TICK_W-1:0] rem_next;
    logic [QUOT_W-1:0] low_reg;
    logic [QUOT_W-1:0] low_next;
    logic [QUOT_W-1:0] quot_reg;
    logic [QUOT_W-1:0] quot_next;
    logic [TICK_W-1:0] dur_reg;
    logic [TICK_W-1:0] dur_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;

    logic [PROD_W-1:0] prod;
    logic [TICK_W:0]   trial;
    logic [TICK_W:0]   diff;

    // quotient stays below width, so the top bits already sit below duration
    assign prod  = PROD_W'(req.width) * PROD_W'(req.elapsed);
    assign trial = {rem_reg, low_reg[QUOT_W-1]};
    assign diff  = trial - {1'b0, dur_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        quot_next = quot_reg;
        dur_next  = dur_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = prod[PROD_W-1:QUOT_W];
            low_next  = prod[QUOT_W-1:0];
            quot_next = '0;
            dur_next  = req.duration;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[TICK_W])
            begin
                rem_next  = diff[TICK_W-1:0];
                quot_next = {quot_reg[QUOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[TICK_W-1:0];
                quot_next = {quot_reg[QUOT_W-2:0], 1'b0};
            end
            low_next = {low_reg[QUOT_W-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(QUOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
        dur_reg  <= dur_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule

@@ rtl/ipt_map.sv @@
// ----------------------------------------------------------------------------
// ipt_map
// source image and column for one pixel at a given slide amount
// ----------------------------------------------------------------------------
module ipt_map
(
    input  logic                       odd_row,
    input  logic [ipt_pkg::COL_W-1:0]  column,
    input  logic [ipt_pkg::PROG_W-1:0] eff_width,
    input  logic [ipt_pkg::PROG_W-1:0] slide,
    output ipt_pkg::map_res_t          res
);
    import ipt_pkg::*;

    logic [PROG_W-1:0] p;
    logic [PROG_W-1:0] w_minus_p;
    logic [PROG_W-1:0] col_ext;
    logic [PROG_W-1:0] scol;
    logic              use2;

    // stored slide may exceed a width written later
    assign p         = (slide > eff_width) ? eff_width : slide;
    assign w_minus_p = eff_width - p;
    assign col_ext   = PROG_W'(column);

    always_comb
    begin
        if (!odd_row)
        begin
            // new image enters from the left
            if (col_ext < p)
            begin
                use2 = 1'b1;
                scol = col_ext + w_minus_p;
            end
            else
            begin
                use2 = 1'b0;
                scol = col_ext - p;
            end
        end
        else
        begin
            // new image enters from the right
            if (col_ext < w_minus_p)
            begin
                use2 = 1'b0;
                scol = col_ext + p;
            end
            else
            begin
                use2 = 1'b1;
                scol = col_ext - w_minus_p;
            end
        end
    end

    assign res.use_second    = use2;
    assign res.source_column = scol[COL_W-1:0];
    assign res.progress      = p;
    assign res.finished      = (p == eff_width);

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks the interlaced push transition mapper against a cycle-free predictor
// of slide amount and source-column mapping, over several register settings
// and handshake idling patterns
// ----------------------------------------------------------------------------
module testbench;
    import ipt_pkg::*;

    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          SETTLE       = 20;
    localparam int          RANDOM_ITEMS = 140;
    localparam int          PHASES       = 8;
    // first tick sits just below the wrap point so later ticks roll over
    localparam logic [31:0] FIRST_TICK   = 32'hFFFF_FE00;

    // one request as queued for the driver
    typedef struct {
        req_kind_t   kind;
        logic [31:0] tick;
        logic [11:0] row;
        logic [11:0] column;
    } pix_req_t;

    logic clk;
    logic rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    ipt_req_if req_ch ();
    ipt_rsp_if rsp_ch ();

    interlaced_push_transition dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_ch    (req_ch),
        .rsp_ch    (rsp_ch)
    );

    // stimulus waiting for the driver, mappings waiting for the block
    pix_req_t pending_q[$];
    map_res_t mapping_q[$];
    pix_req_t drive_item;

    // idling pressure in percent, changed only between phases
    int sender_idle_pct;
    int recv_stall_pct;

    int err_count;
    int cycle_count;

    // predictor copy of registers and state
    logic [31:0] m_duration;
    logic [12:0] m_width;
    logic        m_first;
    logic [31:0] m_start;
    logic [12:0] m_slide;

    // ------------------------------------------------------------------
    // predictor: updates slide state on a frame tick, maps a pixel query
    // ------------------------------------------------------------------
    function automatic map_res_t predict_mapping(input req_kind_t kind,
                                                 input logic [31:0] tk,
                                                 input logic [11:0] rw,
                                                 input logic [11:0] cl);
        logic [31:0] w;
        logic [31:0] p;
        logic [31:0] c;
        logic [31:0] elapsed;
        logic [31:0] scol;
        logic [63:0] prod;
        map_res_t    r;
        // width saturates at the largest supported image
        w = (m_width > 13'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : {19'd0, m_width};
        c = {20'd0, cl};
        r.use_second = 1'b0;
        scol = 32'd0;
        if (kind == REQ_FRAME_TICK)
        begin
            // first tick after reset latches the start time
            if (m_first)
            begin
                m_first = 1'b0;
                m_start = tk;
            end
            elapsed = tk - m_start;
            // a duration of zero never reaches the divide
            if (elapsed >= m_duration)
                m_slide = w[12:0];
            else
            begin
                prod = {32'd0, w} * {32'd0, elapsed};
                m_slide = 13'(prod / {32'd0, m_duration});
            end
        end
        // a stale slide amount is clamped to the current width
        p = ({19'd0, m_slide} > w) ? w : {19'd0, m_slide};
        if (kind == REQ_PIXEL_QUERY)
        begin
            if (!rw[0])
            begin
                // even line: new image enters from the left
                if (c < p)
                begin
                    r.use_second = 1'b1;
                    scol = c + (w - p);
                end
                else
                    scol = c - p;
            end
            else
            begin
                // odd line: new image enters from the right
                if (c < w - p)
                    scol = c + p;
                else
                begin
                    r.use_second = 1'b1;
                    scol = c - (w - p);
                end
            end
        end
        r.source_column = scol[11:0];
        r.progress      = p[12:0];
        r.finished      = (p == w);
        return r;
    endfunction

    // clock and single reset
    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // driver: presents queued requests, holds them until the transfer
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            // previous transfer done or nothing shown, pick the next one
            if (pending_q.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct)
            begin
                drive_item = pending_q.pop_front();
                req_ch.valid    <= 1'b1;
                req_ch.req_type <= drive_item.kind;
                req_ch.tick     <= drive_item.tick;
                req_ch.row      <= drive_item.row;
                req_ch.column   <= drive_item.column;
            end
            else
            begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: stalls the result side, checks result transfers, and
    // predicts a mapping for every request transfer
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin : monitor
        map_res_t got;
        map_res_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            rsp_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
            // result transfer against the oldest prediction
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.use_second    = rsp_ch.use_second;
                got.source_column = rsp_ch.source_column;
                got.progress      = rsp_ch.progress;
                got.finished      = rsp_ch.finished;
                if (mapping_q.size() == 0)
                begin
                    if (err_count < 10)
                        $display("unexpected result: use_second=%0d source_column=%0d progress=%0d finished=%0d",
                                 got.use_second, got.source_column, got.progress,
                                 got.finished);
                    err_count <= err_count + 1;
                end
                else
                begin
                    want = mapping_q.pop_front();
                    if (got !== want)
                    begin
                        if (err_count < 10)
                            $display("mismatch: expected use_second=%0d source_column=%0d progress=%0d finished=%0d, got use_second=%0d source_column=%0d progress=%0d finished=%0d",
                                     want.use_second, want.source_column, want.progress,
                                     want.finished, got.use_second, got.source_column,
                                     got.progress, got.finished);
                        err_count <= err_count + 1;
                    end
                end
            end
            // request transfer, predicted after the check of this edge
            if (req_ch.valid && req_ch.ready)
                mapping_q.push_back(predict_mapping(req_kind_t'(req_ch.req_type),
                                                    req_ch.tick, req_ch.row,
                                                    req_ch.column));
        end
    end

    // watchdog on total run length
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // register write, only issued while nothing is in flight
    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_DURATION)
            m_duration = value;
        else
            m_width = value[12:0];
        @(negedge clk);
    endtask

    // frame tick at a given elapsed time from the first tick
    task automatic add_tick(input logic [31:0] elapsed);
        pix_req_t it;
        it.kind   = REQ_FRAME_TICK;
        it.tick   = FIRST_TICK + elapsed;
        it.row    = 12'($urandom);
        it.column = 12'($urandom);
        pending_q.push_back(it);
    endtask

    task automatic add_query(input logic [11:0] rw, input logic [11:0] cl);
        pix_req_t it;
        it.kind   = REQ_PIXEL_QUERY;
        it.tick   = $urandom;
        it.row    = rw;
        it.column = cl;
        pending_q.push_back(it);
    endtask

    // wait until the driver, the block and the checker are all empty
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_q.size() != 0 || req_ch.valid || mapping_q.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    // elapsed time for a random tick: often an advancing animation, some below,
    // at or just past the duration, some anywhere in the 32-bit range
    function automatic logic [31:0] pick_elapsed(input logic [31:0] dur,
                                                 inout logic [31:0] ramp);
        case ($urandom_range(9, 0))
            0, 1, 2, 3:
            begin
                if (ramp > dur)
                    ramp = 32'd0;
                ramp = ramp + $urandom_range(dur / 8 + 1, 0);
                return ramp;
            end
            4:       return $urandom_range(dur - 1, 0);
            5:       return dur - 1;
            6:       return dur;
            7:       return dur + $urandom_range(64, 1);
            default: return $urandom;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus: directed items, corner settings, then random phases
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic [31:0] dur;
        logic [31:0] wid;
        logic [31:0] eff;
        logic [31:0] ramp;
        logic [11:0] col;

        // every block input known from time zero
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_DURATION;
        cfg_data        = '0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_PIXEL_QUERY;
        req_ch.tick     = '0;
        req_ch.row      = '0;
        req_ch.column   = '0;
        rsp_ch.ready    = 1'b0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        err_count       = 0;
        cycle_count     = 0;

        // predictor reset state
        m_duration = DURATION_RST;
        m_width    = WIDTH_RST;
        m_first    = 1'b1;
        m_start    = 32'd0;
        m_slide    = 13'd0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // queries before any tick: inside the width they read the old image in place
        add_query(12'd0, 12'd0);
        add_query(12'd1, 12'd0);
        add_query(12'hFFF, 12'hFFF);
        // first tick latches start, then a half-way slide
        add_tick(32'd0);
        add_query(12'd1, 12'd639);
        add_tick(32'd500);
        add_query(12'd0, 12'd0);
        add_query(12'd0, 12'd320);
        add_query(12'd1, 12'd319);
        add_query(12'd1, 12'd320);
        // columns past the image width
        add_query(12'd0, 12'hFFF);
        add_query(12'd1, 12'hFFF);
        // just short of, at, and far past the duration (wraps the tick)
        add_tick(32'd999);
        add_query(12'd2, 12'd638);
        add_tick(32'd1000);
        add_query(12'd0, 12'd639);
        add_tick(32'hFFFF_FFFF);
        add_query(12'd3, 12'd0);
        wait_drained();

        // zero width with zero duration
        write_reg(REG_IMAGE_WIDTH, 32'd0);
        write_reg(REG_DURATION, 32'd0);
        add_query(12'd0, 12'd5);
        add_tick(32'd0);
        add_query(12'd1, 12'd5);
        wait_drained();
        // duration of one, width changed after ticks
        write_reg(REG_DURATION, 32'd1);
        write_reg(REG_IMAGE_WIDTH, 32'd300);
        add_query(12'd0, 12'd100);
        add_tick(32'd0);
        add_tick(32'd1);
        add_query(12'd1, 12'd299);
        wait_drained();
        // width above the largest image saturates
        write_reg(REG_IMAGE_WIDTH, 32'd8191);
        write_reg(REG_DURATION, 32'd2);
        add_query(12'd0, 12'd4095);
        add_tick(32'd1);
        add_query(12'd0, 12'd4095);
        add_query(12'd1, 12'd0);
        add_tick(32'd2);
        wait_drained();

        // random phases, each with its own settings and idling pattern
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       begin dur = 32'd1000;      wid = 32'd640;  end
                1:       begin dur = 32'd2;         wid = 32'd1;    end
                2:       begin dur = 32'hFFFF_FFFF; wid = 32'd4096; end
                3:       begin dur = 32'd37;        wid = 32'd640;  end
                4:
                begin
                    dur = $urandom_range(5000, 2);
                    wid = $urandom_range(4096, 1);
                end
                5:
                begin
                    dur = $urandom_range(32'hFFFF_FFFF, 2);
                    wid = $urandom_range(4096, 1);
                end
                6:       begin dur = 32'd256;       wid = 32'd4095; end
                default: begin dur = 32'd3;         wid = 32'd2;    end
            endcase
            case (ph % 4)
                0:       begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin sender_idle_pct = 85; recv_stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  recv_stall_pct = 85; end
                default: begin sender_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            write_reg(REG_DURATION, dur);
            write_reg(REG_IMAGE_WIDTH, wid);
            eff  = (wid > MAX_WIDTH) ? MAX_WIDTH : wid;
            ramp = 32'd0;
            for (int n = 0; n < RANDOM_ITEMS; n++)
            begin
                // roughly one tick per handful of pixels
                if ($urandom_range(4, 0) == 0)
                    add_tick(pick_elapsed(dur, ramp));
                else
                begin
                    if ($urandom_range(9, 0) < 8)
                        col = 12'($urandom_range(eff - 1, 0));
                    else
                        col = 12'($urandom);
                    add_query(12'($urandom), col);
                end
            end
            wait_drained();
        end

        if (err_count == 0 && mapping_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
